@@ rtl/secs_pkg.sv @@
`timescale 1ns / 1ps
// secs_pkg: shared types, codes and the result sequence table of the
// serial eeprom command sequencer; no dependencies
package secs_pkg;

   // sizing
   localparam int PAGE_BYTES   = 128;  // power of two
   localparam int ADDRESS_BITS = 16;
   localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // request modes
   localparam logic [2:0] MODE_START_WRITE = 3'd0;
   localparam logic [2:0] MODE_WRITE_BYTE  = 3'd1;
   localparam logic [2:0] MODE_START_READ  = 3'd2;
   localparam logic [2:0] MODE_READ_BYTE   = 3'd3;
   localparam logic [2:0] MODE_END         = 3'd4;
   localparam logic [2:0] MODE_CHIP_ERASE  = 3'd5;

   // result actions
   localparam logic [1:0] ACT_WAIT    = 2'd0;
   localparam logic [1:0] ACT_SEND    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_REJECT  = 2'd3;

   // device opcodes
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_CE    = 8'hC7;

   // command kinds handed from front to back
   localparam logic [2:0] KIND_REJECT    = 3'd0;
   localparam logic [2:0] KIND_WRITE_HDR = 3'd1;
   localparam logic [2:0] KIND_DATA      = 3'd2;
   localparam logic [2:0] KIND_DATA_PAGE = 3'd3;
   localparam logic [2:0] KIND_READ_HDR  = 3'd4;
   localparam logic [2:0] KIND_READ_BYTE = 3'd5;
   localparam logic [2:0] KIND_END       = 3'd6;
   localparam logic [2:0] KIND_ERASE     = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] tx_byte;
      logic       release_after;
      logic       capture;
      logic       last;
   } result_type;

   function automatic result_type make_result(logic [1:0] act, logic [7:0] b,
                                              logic rel, logic cap, logic lst);
      result_type r;
      r.action        = act;
      r.tx_byte       = b;
      r.release_after = rel;
      r.capture       = cap;
      r.last          = lst;
      return r;
   endfunction

   // wait, write enable, write opcode, address high, address low
   function automatic result_type write_hdr_item(logic [2:0] step, logic [15:0] addr);
      result_type r;
      case (step)
         3'd0:    r = make_result(ACT_WAIT, OP_RDSR, 1'b0, 1'b0, 1'b0);
         3'd1:    r = make_result(ACT_SEND, OP_WREN, 1'b1, 1'b0, 1'b0);
         3'd2:    r = make_result(ACT_SEND, OP_WRITE, 1'b0, 1'b0, 1'b0);
         3'd3:    r = make_result(ACT_SEND, addr[15:8], 1'b0, 1'b0, 1'b0);
         default: r = make_result(ACT_SEND, addr[7:0], 1'b0, 1'b0, 1'b0);
      endcase
      return r;
   endfunction

   // result item number step of a command
   function automatic result_type seq_item(cmd_type cmd, logic [2:0] step);
      result_type r;
      case (cmd.kind)
         KIND_WRITE_HDR: begin
            r = write_hdr_item(step, cmd.addr);
            r.last = (step == 3'd4);
         end
         KIND_DATA: r = make_result(ACT_SEND, cmd.data, 1'b0, 1'b0, 1'b1);
         KIND_DATA_PAGE: begin
            case (step)
               3'd0:    r = make_result(ACT_RELEASE, 8'h00, 1'b0, 1'b0, 1'b0);
               3'd6:    r = make_result(ACT_SEND, cmd.data, 1'b0, 1'b0, 1'b1);
               default: r = write_hdr_item(step - 3'd1, cmd.addr);
            endcase
         end
         KIND_READ_HDR: begin
            case (step)
               3'd0:    r = make_result(ACT_WAIT, OP_RDSR, 1'b0, 1'b0, 1'b0);
               3'd1:    r = make_result(ACT_SEND, OP_READ, 1'b0, 1'b0, 1'b0);
               3'd2:    r = make_result(ACT_SEND, cmd.addr[15:8], 1'b0, 1'b0, 1'b0);
               default: r = make_result(ACT_SEND, cmd.addr[7:0], 1'b0, 1'b0, 1'b1);
            endcase
         end
         KIND_READ_BYTE: r = make_result(ACT_SEND, 8'h00, 1'b0, 1'b1, 1'b1);
         KIND_END:       r = make_result(ACT_RELEASE, 8'h00, 1'b0, 1'b0, 1'b1);
         KIND_ERASE: begin
            case (step)
               3'd0:    r = make_result(ACT_WAIT, OP_RDSR, 1'b0, 1'b0, 1'b0);
               3'd1:    r = make_result(ACT_SEND, OP_WREN, 1'b1, 1'b0, 1'b0);
               default: r = make_result(ACT_SEND, OP_CE, 1'b1, 1'b0, 1'b1);
            endcase
         end
         default: r = make_result(ACT_REJECT, 8'h00, 1'b0, 1'b0, 1'b1);
      endcase
      return r;
   endfunction

endpackage

@@ rtl/spi_eeprom_command_sequencer.sv @@
`timescale 1ns / 1ps
// spi_eeprom_command_sequencer: top level, front, queue and back joined
// uses secs_pkg, secs_front, secs_queue, secs_back
//
// Turns eeprom access requests into the byte stream for a serial link
// layer. Each request gives one to seven result transactions, the final one
// flagged by rsp_last; wrong-session requests and unused modes give a single
// reject. The front checks each request against the session state (open,
// write or read, running address, first data byte) and queues one command;
// a four-deep command queue lets requests be taken at one per cycle while the
// queue is not full, also while the back is busy. The back emits one result
// transaction per cycle when the output register is free or being taken; a
// request gives 1 result for data, read byte, end and reject, 3 for erase, 4
// for start read, 5 for start write, 7 for a data byte on a page boundary;
// the back and its single output port set the sustained rate. Page boundaries
// follow PAGE_BYTES, which must be a power of two. No clearing pass after
// reset: the block is ready in the cycle after reset drops.
module spi_eeprom_command_sequencer import secs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_release_after,
   output logic        rsp_capture,
   output logic        rsp_last
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;

   // queue to back
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // request checking and session tracking
   secs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_address   (req_address),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // decouples request acceptance from result delivery
   secs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // result sequencing and output register
   secs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_release_after (rsp_release_after),
      .rsp_capture       (rsp_capture),
      .rsp_last          (rsp_last)
   );

endmodule

@@ rtl/secs_front.sv @@
`timescale 1ns / 1ps
// secs_front: accepts requests, checks them against the session state and
// turns each into one command for the queue; uses secs_pkg
module secs_front import secs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic        queue_full,
   output logic        push,
   output cmd_type     push_cmd
);

   logic                    open_ff, open_in;
   logic                    writes_ff, writes_in;
   logic                    first_ff, first_in;
   logic [ADDRESS_BITS-1:0] run_addr_ff, run_addr_in;
   logic [ADDRESS_BITS-1:0] start_addr;
   logic                    at_page;

   assign req_ready  = !queue_full;
   assign push       = req_valid && req_ready;
   assign start_addr = ADDRESS_BITS'(req_address);
   assign at_page    = (run_addr_ff[PAGE_BITS-1:0] == '0) && !first_ff;

   always_comb begin
      open_in       = open_ff;
      writes_in     = writes_ff;
      first_in      = first_ff;
      run_addr_in   = run_addr_ff;
      push_cmd.kind = KIND_REJECT;
      push_cmd.addr = 16'(run_addr_ff);
      push_cmd.data = req_data_byte;
      case (req_mode)
         MODE_START_WRITE: begin
            if (!open_ff) begin
               push_cmd.kind = KIND_WRITE_HDR;
               push_cmd.addr = 16'(start_addr);
               open_in       = 1'b1;
               writes_in     = 1'b1;
               first_in      = 1'b1;
               run_addr_in   = start_addr;
            end
         end
         MODE_WRITE_BYTE: begin
            if (open_ff && writes_ff) begin
               push_cmd.kind = at_page ? KIND_DATA_PAGE : KIND_DATA;
               first_in      = 1'b0;
               run_addr_in   = run_addr_ff + 1'b1;
            end
         end
         MODE_START_READ: begin
            if (!open_ff) begin
               push_cmd.kind = KIND_READ_HDR;
               push_cmd.addr = 16'(start_addr);
               open_in       = 1'b1;
               writes_in     = 1'b0;
               first_in      = 1'b1;
               run_addr_in   = start_addr;
            end
         end
         MODE_READ_BYTE: begin
            if (open_ff && !writes_ff) begin
               push_cmd.kind = KIND_READ_BYTE;
               run_addr_in   = run_addr_ff + 1'b1;
            end
         end
         MODE_END: begin
            if (open_ff) begin
               push_cmd.kind = KIND_END;
               open_in       = 1'b0;
               writes_in     = 1'b0;
               first_in      = 1'b1;
            end
         end
         MODE_CHIP_ERASE: begin
            if (!open_ff) begin
               push_cmd.kind = KIND_ERASE;
            end
         end
         default: push_cmd.kind = KIND_REJECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         writes_ff   <= 1'b0;
         first_ff    <= 1'b1;
         run_addr_ff <= '0;
      end else if (push) begin
         open_ff     <= open_in;
         writes_ff   <= writes_in;
         first_ff    <= first_in;
         run_addr_ff <= run_addr_in;
      end
   end

endmodule

@@ rtl/secs_queue.sv @@
`timescale 1ns / 1ps
// secs_queue: short command queue between front and back
// uses secs_pkg
module secs_queue import secs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/secs_back.sv @@
`timescale 1ns / 1ps
// secs_back: steps through the result items of the head command and holds
// each in the output register until taken; uses secs_pkg
module secs_back import secs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_release_after,
   output logic        rsp_capture,
   output logic        rsp_last
);

   logic [2:0] step_ff;
   logic       valid_ff;
   result_type item;
   result_type out_ff;
   logic       load;

   assign item = seq_item(head_cmd, step_ff);
   assign load = head_valid && (!valid_ff || rsp_ready);
   assign pop  = load && item.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff  <= item.last ? 3'd0 : step_ff + 3'd1;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= item;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_action        = out_ff.action;
   assign rsp_tx_byte       = out_ff.tx_byte;
   assign rsp_release_after = out_ff.release_after;
   assign rsp_capture       = out_ff.capture;
   assign rsp_last          = out_ff.last;

endmodule

@@ rtl/secs_checker.sv @@
`timescale 1ns / 1ps
// secs_checker: port-level checks on the result channel, bound to the top
// level; uses secs_pkg and spi_eeprom_command_sequencer
module secs_checker import secs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_action,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_release_after,
   input logic        rsp_capture,
   input logic        rsp_last
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // a reject is always a request's only result
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_REJECT |-> rsp_last && rsp_tx_byte == 8'h00)
      else $error("reject not final");

   // only sends carry release or capture flags
   a_flags_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_release_after || rsp_capture) |-> rsp_action == ACT_SEND)
      else $error("flag on non-send result");

   // a read byte is a lone dummy send
   a_capture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_capture |-> rsp_last && !rsp_release_after
         && rsp_tx_byte == 8'h00)
      else $error("bad read byte result");

endmodule

bind spi_eeprom_command_sequencer secs_checker u_secs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_action        (rsp_action),
   .rsp_tx_byte       (rsp_tx_byte),
   .rsp_release_after (rsp_release_after),
   .rsp_capture       (rsp_capture),
   .rsp_last          (rsp_last)
);

@@ tb/sv/tb_spi_eeprom_command_sequencer.sv @@
`timescale 1ns / 1ps
// tb_spi_eeprom_command_sequencer: self-checking testbench of the serial eeprom
// command sequencer, directed session cases then random sessions and noise
// uses secs_pkg and spi_eeprom_command_sequencer
module tb_spi_eeprom_command_sequencer import secs_pkg::*;;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
   localparam int RANDOM_UNTIL = 205;   // random requests start until this many are sent, directed ones included
   localparam int DRAIN_AT     = 130;   // sender pauses here until all results are in
   localparam int LONG_HOLD_AT = 100;   // receiver stalls long before this result
   localparam int LONG_HOLD    = 160;

   // expected byte stream of the sequencer, kept from accepted requests
   class eeprom_cmd_scoreboard;
      bit                      session_open;
      bit                      session_writes;
      bit                      first_data;
      logic [ADDRESS_BITS-1:0] running_addr;
      result_type              request_results[$];
      result_type              expected_results[$];
      int                      errors;

      function new();
         session_open   = 1'b0;
         session_writes = 1'b0;
         first_data     = 1'b1;
         running_addr   = '0;
         errors         = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void emit(logic [1:0] act, logic [7:0] b, logic rel, logic cap);
         result_type r;
         r.action        = act;
         r.tx_byte       = b;
         r.release_after = rel;
         r.capture       = cap;
         r.last          = 1'b0;
         request_results.push_back(r);
      endfunction

      // status poll, write enable on its own, write opcode, address high then low
      function void emit_write_header(logic [15:0] addr);
         emit(ACT_WAIT, OP_RDSR, 1'b0, 1'b0);
         emit(ACT_SEND, OP_WREN, 1'b1, 1'b0);
         emit(ACT_SEND, OP_WRITE, 1'b0, 1'b0);
         emit(ACT_SEND, addr[15:8], 1'b0, 1'b0);
         emit(ACT_SEND, addr[7:0], 1'b0, 1'b0);
      endfunction

      function void note_request(logic [2:0] mode, logic [15:0] addr, logic [7:0] data);
         result_type r;
         request_results.delete();
         case (mode)
            MODE_START_WRITE: if (!session_open) begin
               emit_write_header(addr);
               session_open   = 1'b1;
               session_writes = 1'b1;
               running_addr   = addr;
               first_data     = 1'b1;
            end
            MODE_WRITE_BYTE: if (session_open && session_writes) begin
               // a page boundary closes the write and reopens it, unless first byte
               if (!first_data && (running_addr % PAGE_BYTES) == 0) begin
                  emit(ACT_RELEASE, 8'h00, 1'b0, 1'b0);
                  emit_write_header(16'(running_addr));
               end
               emit(ACT_SEND, data, 1'b0, 1'b0);
               running_addr = running_addr + 1'b1;
               first_data   = 1'b0;
            end
            MODE_START_READ: if (!session_open) begin
               emit(ACT_WAIT, OP_RDSR, 1'b0, 1'b0);
               emit(ACT_SEND, OP_READ, 1'b0, 1'b0);
               emit(ACT_SEND, addr[15:8], 1'b0, 1'b0);
               emit(ACT_SEND, addr[7:0], 1'b0, 1'b0);
               session_open   = 1'b1;
               session_writes = 1'b0;
               running_addr   = addr;
               first_data     = 1'b1;
            end
            MODE_READ_BYTE: if (session_open && !session_writes) begin
               emit(ACT_SEND, 8'h00, 1'b0, 1'b1);
               running_addr = running_addr + 1'b1;
            end
            MODE_END: if (session_open) begin
               emit(ACT_RELEASE, 8'h00, 1'b0, 1'b0);
               session_open   = 1'b0;
               session_writes = 1'b0;
               first_data     = 1'b1;
            end
            MODE_CHIP_ERASE: if (!session_open) begin
               emit(ACT_WAIT, OP_RDSR, 1'b0, 1'b0);
               emit(ACT_SEND, OP_WREN, 1'b1, 1'b0);
               emit(ACT_SEND, OP_CE, 1'b1, 1'b0);
            end
            default: ;
         endcase
         // wrong session and unused modes
         if (request_results.size() == 0) emit(ACT_REJECT, 8'h00, 1'b0, 1'b0);
         for (int i = 0; i < request_results.size(); i++) begin
            r      = request_results[i];
            r.last = (i == request_results.size() - 1);
            expected_results.push_back(r);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 200) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected: action %0d byte %02h",
                             got.action, got.tx_byte));
            return;
         end
         want = expected_results.pop_front();
         if (got.action !== want.action)
            report($sformatf("action %0d, expected %0d", got.action, want.action));
         if (got.tx_byte !== want.tx_byte)
            report($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
         if (got.release_after !== want.release_after)
            report($sformatf("release_after %0b, expected %0b",
                             got.release_after, want.release_after));
         if (got.capture !== want.capture)
            report($sformatf("capture %0b, expected %0b", got.capture, want.capture));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_action;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_release_after;
   logic        rsp_capture;
   logic        rsp_last;

   eeprom_cmd_scoreboard sb;
   int idle_cycles   = 0;
   int requests_sent = 0;
   int send_burst    = 0;

   spi_eeprom_command_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_release_after (rsp_release_after),
      .rsp_capture       (rsp_capture),
      .rsp_last          (rsp_last)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // monitor: note each accepted request before checking results of the same edge
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         got.action        = rsp_action;
         got.tx_byte       = rsp_tx_byte;
         got.release_after = rsp_release_after;
         got.capture       = rsp_capture;
         got.last          = rsp_last;
         if (req_valid && req_ready) sb.note_request(req_mode, req_address, req_data_byte);
         if (rsp_valid && rsp_ready) sb.check_result(got);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // watchdog on cycles with no transaction
   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls with no-stall bursts, one long hold-off to back up the block
   initial begin : rsp_side
      int gap;
      int burst;
      int taken;
      burst = 0;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == LONG_HOLD_AT) begin
            gap = LONG_HOLD;
         end else if (burst > 0) begin
            burst--;
            gap = 0;
         end else if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 30);
            gap   = 0;
         end else begin
            gap = $urandom_range(0, 11);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // one request transaction; valid stays up across back-to-back requests
   task automatic send_request(input logic [2:0] mode, input logic [15:0] addr,
                               input logic [7:0] data);
      int gap;
      if (send_burst > 0) begin
         send_burst--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         send_burst = $urandom_range(8, 30);
         gap        = 0;
      end else begin
         gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_address   <= addr;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // open a write or read session, move a few bytes with a stray request now and then,
   // and usually close it; starts cluster just below page boundaries
   task automatic run_session(input bit writes);
      logic [15:0] base;
      logic [2:0]  stray;
      int          count;
      if ($urandom_range(0, 1))
         base = 16'($urandom_range(0, 511) * PAGE_BYTES - $urandom_range(0, 5));
      else
         base = 16'($urandom());
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_request(writes ? MODE_START_WRITE : MODE_START_READ, base, 8'($urandom()));
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: stray = MODE_START_WRITE;
               1: stray = MODE_START_READ;
               2: stray = MODE_CHIP_ERASE;
               default: stray = writes ? MODE_READ_BYTE : MODE_WRITE_BYTE;
            endcase
            send_request(stray, 16'($urandom()), 8'($urandom()));
         end
         send_request(writes ? MODE_WRITE_BYTE : MODE_READ_BYTE, 16'($urandom()),
                      8'($urandom()));
      end
      if ($urandom_range(0, 9) != 0) send_request(MODE_END, 16'($urandom()), 8'($urandom()));
   endtask

   initial begin : req_side
      int choice;
      bit drained;
      drained = 1'b0;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // requests outside any session and unused modes
      send_request(MODE_WRITE_BYTE, 16'hFFFF, 8'hFF);
      send_request(MODE_READ_BYTE, 16'h0000, 8'h00);
      send_request(MODE_END, 16'h5A5A, 8'hA5);
      send_request(3'd6, 16'hFFFF, 8'hFF);
      send_request(3'd7, 16'h0000, 8'h00);
      // write across the top of the address space: wrap, then a page reissue
      send_request(MODE_START_WRITE, 16'hFFFE, 8'h3C);
      send_request(MODE_WRITE_BYTE, 16'h0000, 8'h00);
      send_request(MODE_WRITE_BYTE, 16'h1234, 8'hFF);
      send_request(MODE_WRITE_BYTE, 16'hFFFF, 8'hA5);
      // wrong-session requests inside a write session
      send_request(MODE_START_WRITE, 16'h0100, 8'h11);
      send_request(MODE_START_READ, 16'h0200, 8'h22);
      send_request(MODE_CHIP_ERASE, 16'h0300, 8'h33);
      send_request(MODE_READ_BYTE, 16'h0400, 8'h44);
      send_request(MODE_END, 16'h0000, 8'h00);
      // first data byte on a boundary goes out without a reissue
      send_request(MODE_START_WRITE, 16'h0080, 8'h00);
      send_request(MODE_WRITE_BYTE, 16'h8000, 8'h5A);
      send_request(MODE_WRITE_BYTE, 16'h7FFF, 8'hC3);
      send_request(MODE_END, 16'hFFFF, 8'hFF);
      send_request(MODE_CHIP_ERASE, 16'hAAAA, 8'h55);
      // read across the wrap, then a write byte in a read session
      send_request(MODE_START_READ, 16'hFFFF, 8'h81);
      send_request(MODE_READ_BYTE, 16'h5555, 8'h7E);
      send_request(MODE_READ_BYTE, 16'hAAAA, 8'h18);
      send_request(MODE_WRITE_BYTE, 16'h0F0F, 8'hE7);
      send_request(MODE_END, 16'hF0F0, 8'h00);

      while (requests_sent < RANDOM_UNTIL) begin
         // one quiet pause with nothing in flight
         if (!drained && requests_sent >= DRAIN_AT) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         choice = $urandom_range(0, 9);
         if (choice < 5) run_session(1'b1);
         else if (choice < 8) run_session(1'b0);
         else if (choice == 8) send_request(MODE_CHIP_ERASE, 16'($urandom()), 8'($urandom()));
         else send_request(3'($urandom_range(0, 7)), 16'($urandom()), 8'($urandom()));
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      // catch anything the block sends beyond the expected stream
      repeat (24) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
